>>> rtl/mjdcal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mjdcal_pkg;

  // calendar group lengths in days
  localparam int unsigned DAYS_400Y = 146097;
  localparam int unsigned DAYS_100Y = 36524;
  localparam int unsigned DAYS_4Y   = 1461;
  localparam int unsigned DAYS_1Y   = 365;

  // day number span and offset to a day count from 0001-01-01
  localparam int MJD_MAX     = 2973483;
  localparam int DAYS_OFFSET = 678575;

  // reciprocal estimates: the estimate is the true quotient or one below it
  localparam int unsigned Q400_SHIFT = 22;
  localparam int unsigned Q400_RECIP = (1 << Q400_SHIFT) / DAYS_400Y;
  localparam int unsigned Q4_SHIFT   = 16;
  localparam int unsigned Q4_RECIP   = (1 << Q4_SHIFT) / DAYS_4Y;

  // pipeline depth from input register to output register
  localparam int unsigned NUM_STAGES = 9;

  // field widths
  localparam int unsigned DAYNUM_W = 23;
  localparam int unsigned FRAC_W   = 32;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINSEC_W = 6;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 40;

  typedef logic [8:0] yday_t;
  typedef logic [3:0] mon_idx_t;

  // first day of each month within the year, counted from zero
  function automatic yday_t month_start(input mon_idx_t idx, input logic leap);
    yday_t base;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    // february 29 pushes every later month by one day
    if (leap && (idx >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mjd_to_calendar_date_time.sv
// path: an accepted input transaction passes stage registers s0 through s8 before its result drives m_tvalid
// throughput: one transaction per cycle unless m_tready stalls, set by the nine-stage register pipeline
// a stall on m_tready freezes every stage at once, so nothing is lost or repeated
// reset (rst, synchronous, active high) clears the stage valid bits only
`timescale 1ns / 1ps
`default_nettype none

module mjd_to_calendar_date_time
  import mjdcal_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // day_number [22:0], day_fraction [54:23], zero [55]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // year [13:0], month [17:14], day [22:18], hour [27:23], minute [33:28], second [39:34]
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // out_of_range [0]
  output logic                       m_tuser
);

  logic [NUM_STAGES-1:0] valid;
  logic                  en;

  // stage 0: day count and range check
  logic [21:0]           s0_days;
  logic                  s0_bad;
  logic [FRAC_W-1:0]     s0_frac;
  // stage 1: 400-year estimate, hour
  logic [21:0]           s1_days;
  logic [4:0]            s1_q400;
  logic                  s1_bad;
  logic [HOUR_W-1:0]     s1_hour;
  logic [FRAC_W-1:0]     s1_frac;
  // stage 2: 400-year correction, minute
  logic [17:0]           s2_rem;
  logic [4:0]            s2_q400;
  logic                  s2_bad;
  logic [HOUR_W-1:0]     s2_hour;
  logic [MINSEC_W-1:0]   s2_minute;
  logic [FRAC_W-1:0]     s2_frac;
  // stage 3: 100-year split, second
  logic [15:0]           s3_rem;
  logic [1:0]            s3_q100;
  logic [YEAR_W-1:0]     s3_year;
  logic                  s3_bad;
  logic [HOUR_W-1:0]     s3_hour;
  logic [MINSEC_W-1:0]   s3_minute;
  logic [MINSEC_W-1:0]   s3_second;
  // stage 4: 4-year estimate
  logic [15:0]           s4_rem;
  logic [4:0]            s4_q4;
  logic [1:0]            s4_q100;
  logic [YEAR_W-1:0]     s4_year;
  logic                  s4_bad;
  logic [HOUR_W-1:0]     s4_hour;
  logic [MINSEC_W-1:0]   s4_minute;
  logic [MINSEC_W-1:0]   s4_second;
  // stage 5: 4-year correction
  logic [10:0]           s5_rem;
  logic [4:0]            s5_q4;
  logic [1:0]            s5_q100;
  logic [YEAR_W-1:0]     s5_year;
  logic                  s5_bad;
  logic [HOUR_W-1:0]     s5_hour;
  logic [MINSEC_W-1:0]   s5_minute;
  logic [MINSEC_W-1:0]   s5_second;
  // stage 6: 1-year split and leap flag
  yday_t                 s6_rem;
  logic                  s6_leap;
  logic [YEAR_W-1:0]     s6_year;
  logic                  s6_bad;
  logic [HOUR_W-1:0]     s6_hour;
  logic [MINSEC_W-1:0]   s6_minute;
  logic [MINSEC_W-1:0]   s6_second;
  // stage 7: month index
  yday_t                 s7_rem;
  mon_idx_t              s7_mon;
  logic                  s7_leap;
  logic [YEAR_W-1:0]     s7_year;
  logic                  s7_bad;
  logic [HOUR_W-1:0]     s7_hour;
  logic [MINSEC_W-1:0]   s7_minute;
  logic [MINSEC_W-1:0]   s7_second;
  // stage 8: output register
  logic [YEAR_W-1:0]     s8_year;
  logic [MONTH_W-1:0]    s8_month;
  logic [DAY_W-1:0]      s8_day;
  logic                  s8_bad;
  logic [HOUR_W-1:0]     s8_hour;
  logic [MINSEC_W-1:0]   s8_minute;
  logic [MINSEC_W-1:0]   s8_second;

  // whole pipeline advances unless a finished result is held back
  assign en       = !valid[NUM_STAGES-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = valid[NUM_STAGES-1];
  assign m_tdata  = {s8_second, s8_minute, s8_hour, s8_day, s8_month, s8_year};
  assign m_tuser  = s8_bad;

  // stage 0 logic: offset to days since 0001-01-01
  logic signed [DAYNUM_W-1:0] in_mjd;
  logic signed [23:0]         in_since;
  logic                       in_bad;

  always_comb begin
    in_mjd   = $signed(s_tdata[DAYNUM_W-1:0]);
    in_since = 24'(in_mjd) + 24'(DAYS_OFFSET);
    in_bad   = (in_mjd > DAYNUM_W'(MJD_MAX)) || in_since[23];
  end

  // stage 1 logic: reciprocal estimate of the 400-year count, hour product
  logic [26:0] p400;
  logic [36:0] t_hour;

  always_comb begin
    p400   = 27'(s0_days) * 27'(Q400_RECIP);
    t_hour = 37'(s0_frac) * 37'd24;
  end

  // stage 2 logic: remainder with one correction step, minute product
  logic [22:0] prod400;
  logic [22:0] rem400_est;
  logic [17:0] rem400;
  logic [4:0]  q400_fix;
  logic [37:0] t_min;

  always_comb begin
    prod400    = 23'(s1_q400) * 23'(DAYS_400Y);
    rem400_est = {1'b0, s1_days} - prod400;
    if (rem400_est >= 23'(DAYS_400Y)) begin
      rem400   = 18'(rem400_est - 23'(DAYS_400Y));
      q400_fix = s1_q400 + 5'd1;
    end else begin
      rem400   = rem400_est[17:0];
      q400_fix = s1_q400;
    end
    t_min = 38'(s1_frac) * 38'd60;
  end

  // stage 3 logic: 100-year count clamps at three, second product
  logic [1:0]  q100;
  logic [17:0] rem100;
  logic [37:0] t_sec;

  always_comb begin
    if (s2_rem >= 18'(3 * DAYS_100Y)) begin
      q100 = 2'd3;
    end else if (s2_rem >= 18'(2 * DAYS_100Y)) begin
      q100 = 2'd2;
    end else if (s2_rem >= 18'(DAYS_100Y)) begin
      q100 = 2'd1;
    end else begin
      q100 = 2'd0;
    end
    rem100 = s2_rem - 18'(q100) * 18'(DAYS_100Y);
    t_sec  = 38'(s2_frac) * 38'd60;
  end

  // stage 4 logic: reciprocal estimate of the 4-year count
  logic [21:0] p4;

  always_comb begin
    p4 = 22'(s3_rem) * 22'(Q4_RECIP);
  end

  // stage 5 logic: 4-year remainder with one correction step
  logic [16:0] rem4_est;
  logic [10:0] rem4;
  logic [4:0]  q4_fix;

  always_comb begin
    rem4_est = {1'b0, s4_rem} - 17'(s4_q4) * 17'(DAYS_4Y);
    if (rem4_est >= 17'(DAYS_4Y)) begin
      rem4   = 11'(rem4_est - 17'(DAYS_4Y));
      q4_fix = s4_q4 + 5'd1;
    end else begin
      rem4   = rem4_est[10:0];
      q4_fix = s4_q4;
    end
  end

  // stage 6 logic: 1-year count clamps at three, centuries other than the fourth skip leap
  logic [1:0]  q1;
  logic [10:0] rem1;
  logic        leap;

  always_comb begin
    if (s5_rem >= 11'(3 * DAYS_1Y)) begin
      q1 = 2'd3;
    end else if (s5_rem >= 11'(2 * DAYS_1Y)) begin
      q1 = 2'd2;
    end else if (s5_rem >= 11'(DAYS_1Y)) begin
      q1 = 2'd1;
    end else begin
      q1 = 2'd0;
    end
    rem1 = s5_rem - 11'(q1) * 11'(DAYS_1Y);
    leap = (q1 == 2'd3) && !((s5_q4 == 5'd24) && (s5_q100 != 2'd3));
  end

  // stage 7 logic: month index counts the month starts already passed
  mon_idx_t mon_cnt;

  always_comb begin
    mon_cnt = '0;
    for (int k = 1; k < 12; k++) begin
      if (s6_rem >= month_start(mon_idx_t'(k), s6_leap)) begin
        mon_cnt = mon_cnt + 4'd1;
      end
    end
  end

  // stage 8 logic: day of month, date fields zeroed when out of span
  yday_t day_off;

  always_comb begin
    day_off = s7_rem - month_start(s7_mon, s7_leap) + 9'd1;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[NUM_STAGES-2:0], s_tvalid};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      s0_days   <= in_since[21:0];
      s0_bad    <= in_bad;
      s0_frac   <= s_tdata[DAYNUM_W +: FRAC_W];

      s1_days   <= s0_days;
      s1_q400   <= p400[Q400_SHIFT +: 5];
      s1_bad    <= s0_bad;
      s1_hour   <= t_hour[FRAC_W +: HOUR_W];
      s1_frac   <= t_hour[FRAC_W-1:0];

      s2_rem    <= rem400;
      s2_q400   <= q400_fix;
      s2_bad    <= s1_bad;
      s2_hour   <= s1_hour;
      s2_minute <= t_min[FRAC_W +: MINSEC_W];
      s2_frac   <= t_min[FRAC_W-1:0];

      s3_rem    <= rem100[15:0];
      s3_q100   <= q100;
      s3_year   <= YEAR_W'(s2_q400) * YEAR_W'(400) + YEAR_W'(q100) * YEAR_W'(100);
      s3_bad    <= s2_bad;
      s3_hour   <= s2_hour;
      s3_minute <= s2_minute;
      s3_second <= t_sec[FRAC_W +: MINSEC_W];

      s4_rem    <= s3_rem;
      s4_q4     <= p4[Q4_SHIFT +: 5];
      s4_q100   <= s3_q100;
      s4_year   <= s3_year;
      s4_bad    <= s3_bad;
      s4_hour   <= s3_hour;
      s4_minute <= s3_minute;
      s4_second <= s3_second;

      s5_rem    <= rem4;
      s5_q4     <= q4_fix;
      s5_q100   <= s4_q100;
      s5_year   <= s4_year + YEAR_W'({q4_fix, 2'b00});
      s5_bad    <= s4_bad;
      s5_hour   <= s4_hour;
      s5_minute <= s4_minute;
      s5_second <= s4_second;

      s6_rem    <= rem1[8:0];
      s6_leap   <= leap;
      s6_year   <= s5_year + YEAR_W'(q1) + YEAR_W'(1);
      s6_bad    <= s5_bad;
      s6_hour   <= s5_hour;
      s6_minute <= s5_minute;
      s6_second <= s5_second;

      s7_rem    <= s6_rem;
      s7_mon    <= mon_cnt;
      s7_leap   <= s6_leap;
      s7_year   <= s6_year;
      s7_bad    <= s6_bad;
      s7_hour   <= s6_hour;
      s7_minute <= s6_minute;
      s7_second <= s6_second;

      s8_year   <= s7_bad ? '0 : s7_year;
      s8_month  <= s7_bad ? '0 : s7_mon + 4'd1;
      s8_day    <= s7_bad ? '0 : day_off[DAY_W-1:0];
      s8_bad    <= s7_bad;
      s8_hour   <= s7_hour;
      s8_minute <= s7_minute;
      s8_second <= s7_second;
    end
  end

endmodule

`default_nettype wire
